### sv/acfq_pkg.sv
// shared types, codes and the frame padding mask for the access category frame queues
`default_nettype none

package acfq_pkg;

	localparam int NUM_QUEUES  = 4;
	localparam int FRAME_BYTES = 100;

	typedef enum logic [1:0] {
		OP_ENQ   = 2'd0,
		OP_DEQ   = 2'd1,
		OP_CLEAR = 2'd2,
		OP_BAD   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_EMPTY = 2'd2,
		STAT_BADOP = 2'd3
	} stat_t;

	// bytes at or past the frame length are padding and stored as zero
	function automatic logic [63:0] pad_mask(input logic [3:0] idx);
		logic [63:0] m;
		logic [7:0]  start;
		m     = '0;
		start = {1'b0, idx, 3'b000};
		for (int b = 0; b < 8; b++) begin
			if ((32'(start) + b) < FRAME_BYTES) begin
				m[b*8 +: 8] = 8'hff;
			end
		end
		return m;
	endfunction

endpackage

`default_nettype wire

### sv/acfq_ram.sv
// generic single-write, single-read ram with registered read data
`default_nettype none

module acfq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

### sv/access_category_frame_queues_top.sv
// top level of the access category frame queues: four ring queues of frames in ram
//
// s_ channel takes one operation per transfer: enqueue one frame word, dequeue a frame,
// clear all queues, or an unknown code. m_ channel returns the results, tlast marking
// the final result of each operation.
// enqueue, clear, unknown op and dequeue of an empty queue give one result, registered
// in the cycle after the transfer; while m_tready is high s_tready stays high, so one
// such operation per cycle. a dequeue of a stored frame streams FRAME_WORDS words
// through the frame ram read register and the result register, one word per cycle while
// m_tready is high; the frame ram read port sets that rate. s_tready is low meanwhile.
// reset empties every queue (pointers zero, all slots free); the frame and rate/power
// rams hold no reset value and are read only at committed slots, unwritten words too.
// when m_tready is low the result register holds and the ram read is held back, so
// no word is dropped; new operations wait until the output register can take a result.
`default_nettype none

module access_category_frame_queues_top
	import acfq_pkg::*;
#(
	parameter int QUEUE_SLOTS = 4,
	parameter int FRAME_WORDS = 13
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// access_category[1:0], word_index[5:2], frame_word[69:6], data_rate[76:70],
	// tx_power[80:77], zero fill
	input  wire logic [87:0] s_tdata,
	// operation[1:0]
	input  wire logic [1:0]  s_tuser,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// out_word[63:0], out_rate[70:64], out_power[74:71], zero fill
	output logic      [79:0] m_tdata,
	// status[1:0]
	output logic      [1:0]  m_tuser,
	output logic             m_tlast
);

	localparam int SW = $clog2(QUEUE_SLOTS);
	localparam int WW = (FRAME_WORDS > 1) ? $clog2(FRAME_WORDS) : 1;
	localparam int KW = $clog2(FRAME_WORDS + 1);
	localparam int FW = $clog2(QUEUE_SLOTS + 1);
	localparam int QW = $clog2(NUM_QUEUES);
	localparam int FRAME_DEPTH = NUM_QUEUES << (SW + WW);
	localparam int META_DEPTH  = NUM_QUEUES << SW;

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_DEQ  = 2'b10
	} state_t;

	state_t state_q;

	logic [SW-1:0] rslot_q [NUM_QUEUES];
	logic [SW-1:0] wslot_q [NUM_QUEUES];
	logic [FW-1:0] free_q  [NUM_QUEUES];

	logic [QW-1:0] dq_q;
	logic [SW-1:0] dslot_q;
	logic [KW-1:0] k_q;
	logic          rd_v_s1;
	logic          last_s1;

	logic          m_tvalid_q;
	logic [1:0]    stat_q;
	logic [63:0]   word_q;
	logic [6:0]    rate_q;
	logic [3:0]    pwr_q;
	logic          last_q;

	op_t           op;
	logic [QW-1:0] ac;
	logic [3:0]    wi;
	logic [63:0]   fword;
	logic [6:0]    rate;
	logic [3:0]    pwr;

	logic          s_acc;
	logic          full;
	logic          empty;
	logic          idx_ok;
	logic          idx_last;
	logic          deq_go;
	logic          single;
	logic [1:0]    single_stat;
	logic          out_free;
	logic          rd_issue;
	logic          load_s1;

	logic          fr_we;
	logic          meta_we;
	logic [63:0]   fr_rdata;
	logic [10:0]   meta_rdata;

	assign op    = op_t'(s_tuser);
	assign ac    = s_tdata[1:0];
	assign wi    = s_tdata[5:2];
	assign fword = s_tdata[69:6];
	assign rate  = s_tdata[76:70];
	assign pwr   = s_tdata[80:77];

	assign out_free = !m_tvalid_q || m_tready;
	assign s_tready = (state_q == S_IDLE) && out_free;
	assign s_acc    = s_tvalid && s_tready;

	assign full     = (free_q[ac] == '0);
	assign empty    = (32'(free_q[ac]) >= QUEUE_SLOTS);
	assign idx_ok   = (32'(wi) < FRAME_WORDS);
	assign idx_last = (32'(wi) == FRAME_WORDS - 1);

	assign deq_go  = s_acc && (op == OP_DEQ) && !empty;
	assign single  = s_acc && !deq_go;
	assign fr_we   = s_acc && (op == OP_ENQ) && !full && idx_ok;
	assign meta_we = fr_we && idx_last;

	always_comb begin
		unique case (op)
			OP_ENQ:   single_stat = full ? STAT_FULL : STAT_OK;
			OP_DEQ:   single_stat = STAT_EMPTY;
			OP_CLEAR: single_stat = STAT_OK;
			OP_BAD:   single_stat = STAT_BADOP;
			default:  single_stat = STAT_BADOP;
		endcase
	end

	assign rd_issue = (state_q == S_DEQ) && (32'(k_q) < FRAME_WORDS) && (!rd_v_s1 || out_free);
	assign load_s1  = rd_v_s1 && out_free;

	acfq_ram #(
		.WIDTH(64),
		.DEPTH(FRAME_DEPTH)
	) u_frame_ram (
		.clk  (clk),
		.we   (fr_we),
		.waddr({ac, wslot_q[ac], WW'(wi)}),
		.wdata(fword & pad_mask(wi)),
		.re   (rd_issue),
		.raddr({dq_q, dslot_q, k_q[WW-1:0]}),
		.rdata(fr_rdata)
	);

	acfq_ram #(
		.WIDTH(11),
		.DEPTH(META_DEPTH)
	) u_meta_ram (
		.clk  (clk),
		.we   (meta_we),
		.waddr({ac, wslot_q[ac]}),
		.wdata({pwr, rate}),
		.re   (rd_issue && (k_q == '0)),
		.raddr({dq_q, dslot_q}),
		.rdata(meta_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			k_q        <= '0;
			rd_v_s1    <= 1'b0;
			m_tvalid_q <= 1'b0;
			for (int i = 0; i < NUM_QUEUES; i++) begin
				rslot_q[i] <= '0;
				wslot_q[i] <= '0;
				free_q[i]  <= FW'(QUEUE_SLOTS);
			end
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (deq_go) begin
						state_q <= S_DEQ;
					end
				end
				S_DEQ: begin
					if ((32'(k_q) == FRAME_WORDS) && !rd_v_s1) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase

			if (deq_go) begin
				k_q <= '0;
			end else if (rd_issue) begin
				k_q <= k_q + 1'b1;
			end

			if (rd_issue) begin
				rd_v_s1 <= 1'b1;
			end else if (load_s1) begin
				rd_v_s1 <= 1'b0;
			end

			if (single || load_s1) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end

			if (s_acc) begin
				if (op == OP_CLEAR) begin
					for (int i = 0; i < NUM_QUEUES; i++) begin
						rslot_q[i] <= '0;
						wslot_q[i] <= '0;
						free_q[i]  <= FW'(QUEUE_SLOTS);
					end
				end else if (meta_we) begin
					wslot_q[ac] <= (32'(wslot_q[ac]) == QUEUE_SLOTS - 1) ? '0
						: wslot_q[ac] + 1'b1;
					free_q[ac]  <= free_q[ac] - 1'b1;
				end else if (deq_go) begin
					rslot_q[ac] <= (32'(rslot_q[ac]) == QUEUE_SLOTS - 1) ? '0
						: rslot_q[ac] + 1'b1;
					free_q[ac]  <= free_q[ac] + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (deq_go) begin
			dq_q    <= ac;
			dslot_q <= rslot_q[ac];
		end
		if (rd_issue) begin
			last_s1 <= (32'(k_q) == FRAME_WORDS - 1);
		end
		if (single) begin
			stat_q <= single_stat;
			word_q <= '0;
			rate_q <= '0;
			pwr_q  <= '0;
			last_q <= 1'b1;
		end else if (load_s1) begin
			stat_q <= STAT_OK;
			word_q <= fr_rdata;
			rate_q <= meta_rdata[6:0];
			pwr_q  <= meta_rdata[10:7];
			last_q <= last_s1;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {5'b0, pwr_q, rate_q, word_q};
	assign m_tuser  = stat_q;
	assign m_tlast  = last_q;

	a_s1_only_in_deq: assert property (@(posedge clk) disable iff (!arst_n)
		rd_v_s1 |-> (state_q == S_DEQ))
		else $error("ram read data pending outside a dequeue");

	a_deq_enters: assert property (@(posedge clk) disable iff (!arst_n)
		deq_go |=> (state_q == S_DEQ) && (k_q == '0))
		else $error("dequeue of a stored frame did not start streaming");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(k_q) <= FRAME_WORDS)
		else $error("word counter ran past the frame length");

	a_free_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(32'(free_q[0]) <= QUEUE_SLOTS) && (32'(free_q[1]) <= QUEUE_SLOTS) &&
		(32'(free_q[2]) <= QUEUE_SLOTS) && (32'(free_q[3]) <= QUEUE_SLOTS))
		else $error("free slot count above queue size");

	a_no_load_clash: assert property (@(posedge clk) disable iff (!arst_n)
		!(single && load_s1))
		else $error("single result and frame word loaded together");

endmodule

`default_nettype wire

### bench/tb_top.sv
// self-checking bench for the access category frame queues: planned operations, predicted results
module tb_top;
	import acfq_pkg::*;

	localparam int SLOTS       = 4;
	localparam int WORDS       = 13;
	localparam int LAST_IDX    = WORDS - 1;
	localparam int RAND_ITEMS  = 230;
	localparam int STALL_LIMIT = 5000;
	localparam int MAX_REPORTS = 40;

	typedef struct packed {
		op_t         op;
		logic [1:0]  ac;
		logic [3:0]  idx;
		logic [63:0] word;
		logic [6:0]  rate;
		logic [3:0]  pwr;
	} frame_op_t;

	typedef struct packed {
		stat_t       st;
		logic [63:0] word;
		logic [6:0]  rate;
		logic [3:0]  pwr;
		logic        last;
	} frame_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid;
	logic        s_tready;
	logic [87:0] s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [79:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        m_tlast;

	access_category_frame_queues_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// operations waiting to be sent and results waiting to come back
	frame_op_t     pending_ops[$];
	frame_result_t frame_results[$];
	frame_op_t     cur_op;

	// queue model
	logic [63:0] frame_mem [NUM_QUEUES*SLOTS*WORDS];
	logic [6:0]  rate_mem [NUM_QUEUES*SLOTS];
	logic [3:0]  pwr_mem [NUM_QUEUES*SLOTS];
	int          rd_slot [NUM_QUEUES] = '{default: 0};
	int          wr_slot [NUM_QUEUES] = '{default: 0};
	int          free_cnt [NUM_QUEUES] = '{default: SLOTS};

	// stimulus planning view, keeps every dequeued word a written one
	logic [WORDS-1:0] plan_written [NUM_QUEUES][SLOTS] = '{default: '0};
	int               plan_wslot [NUM_QUEUES] = '{default: 0};
	int               plan_free [NUM_QUEUES] = '{default: SLOTS};

	int n_planned = 1;
	int n_accepted = 0;
	int n_errors = 0;
	int n_results = 0;
	int n_frames_out = 0;
	int n_full = 0;
	int n_empty = 0;
	int n_clears = 0;
	int n_badops = 0;
	int idle_cycles = 0;

	function automatic void push_result(stat_t st, logic [63:0] word, logic [6:0] rate,
			logic [3:0] pwr, logic last);
		frame_results.push_back('{st: st, word: word, rate: rate, pwr: pwr, last: last});
	endfunction

	function automatic void predict_frame_op(frame_op_t it);
		int          base;
		int          valid;
		logic [63:0] keep;
		case (it.op)
			OP_ENQ: begin
				if (free_cnt[it.ac] == 0) begin
					n_full++;
					push_result(STAT_FULL, '0, '0, '0, 1'b1);
				end else begin
					if (it.idx < WORDS) begin
						base  = it.ac * SLOTS + wr_slot[it.ac];
						valid = FRAME_BYTES - int'(it.idx) * 8;
						if (valid <= 0) keep = '0;
						else if (valid >= 8) keep = '1;
						else keep = (64'd1 << (8 * valid)) - 64'd1;
						frame_mem[base*WORDS + it.idx] = it.word & keep;
						if (it.idx == LAST_IDX) begin
							rate_mem[base] = it.rate;
							pwr_mem[base]  = it.pwr;
							wr_slot[it.ac] = (wr_slot[it.ac] + 1) % SLOTS;
							free_cnt[it.ac]--;
						end
					end
					push_result(STAT_OK, '0, '0, '0, 1'b1);
				end
			end
			OP_DEQ: begin
				if (free_cnt[it.ac] >= SLOTS) begin
					n_empty++;
					push_result(STAT_EMPTY, '0, '0, '0, 1'b1);
				end else begin
					base = it.ac * SLOTS + rd_slot[it.ac];
					for (int k = 0; k < WORDS; k++) begin
						push_result(STAT_OK, frame_mem[base*WORDS + k], rate_mem[base],
							pwr_mem[base], k == LAST_IDX);
					end
					rd_slot[it.ac] = (rd_slot[it.ac] + 1) % SLOTS;
					free_cnt[it.ac]++;
					n_frames_out++;
				end
			end
			OP_CLEAR: begin
				for (int q = 0; q < NUM_QUEUES; q++) begin
					rd_slot[q]  = 0;
					wr_slot[q]  = 0;
					free_cnt[q] = SLOTS;
				end
				n_clears++;
				push_result(STAT_OK, '0, '0, '0, 1'b1);
			end
			default: begin
				n_badops++;
				push_result(STAT_BADOP, '0, '0, '0, 1'b1);
			end
		endcase
	endfunction

	// a commit word is only sent once every word of its slot has been written
	function automatic void plan_op(frame_op_t it);
		if (it.op == OP_ENQ && plan_free[it.ac] != 0) begin
			if (it.idx == LAST_IDX &&
					plan_written[it.ac][plan_wslot[it.ac]][LAST_IDX-1:0] != '1) begin
				it.idx = 4'(WORDS + $urandom_range(0, 2));
			end
			if (it.idx < WORDS) begin
				plan_written[it.ac][plan_wslot[it.ac]][it.idx] = 1'b1;
				if (it.idx == LAST_IDX) begin
					plan_wslot[it.ac] = (plan_wslot[it.ac] + 1) % SLOTS;
					plan_free[it.ac]--;
				end
			end
		end else if (it.op == OP_DEQ && plan_free[it.ac] < SLOTS) begin
			plan_free[it.ac]++;
		end else if (it.op == OP_CLEAR) begin
			for (int q = 0; q < NUM_QUEUES; q++) begin
				plan_wslot[q] = 0;
				plan_free[q]  = SLOTS;
			end
		end
		pending_ops.push_back(it);
	endfunction

	function automatic int idle_phase();
		if (n_accepted < n_planned / 3) return 0;
		if (n_accepted < 2 * n_planned / 3) return 1;
		return 2;
	endfunction

	function automatic logic sender_idles();
		int p;
		p = idle_phase();
		if (p == 0) return $urandom_range(0, 99) < 28;
		if (p == 1) return $urandom_range(0, 99) < 74;
		return 1'b0;
	endfunction

	function automatic logic receiver_stalls();
		int p;
		p = idle_phase();
		if (p == 0) return $urandom_range(0, 99) < 74;
		if (p == 1) return $urandom_range(0, 99) < 28;
		return 1'b0;
	endfunction

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		if (n_errors < MAX_REPORTS) begin
			$display("mismatch on result %0d, %s: got %h expected %h", n_results, what, got,
				want);
		end
		n_errors++;
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			s_tuser  <= OP_ENQ;
		end else begin
			if (s_tvalid && s_tready) begin
				predict_frame_op(cur_op);
				n_accepted++;
			end
			if (!s_tvalid || s_tready) begin
				if (pending_ops.size() != 0 && !sender_idles()) begin
					cur_op = pending_ops.pop_front();
					s_tvalid <= 1'b1;
					s_tdata  <= {7'b0, cur_op.pwr, cur_op.rate, cur_op.word, cur_op.idx, cur_op.ac};
					s_tuser  <= cur_op.op;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		frame_result_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (frame_results.size() == 0) begin
					report_mismatch("unexpected result word", m_tdata[63:0], '0);
				end else begin
					want = frame_results.pop_front();
					if (m_tuser !== want.st) report_mismatch("status", m_tuser, want.st);
					if (m_tdata[63:0] !== want.word) report_mismatch("word", m_tdata[63:0], want.word);
					if (m_tdata[70:64] !== want.rate) report_mismatch("rate", m_tdata[70:64], want.rate);
					if (m_tdata[74:71] !== want.pwr) report_mismatch("power", m_tdata[74:71], want.pwr);
					if (m_tlast !== want.last) report_mismatch("last", m_tlast, want.last);
				end
				n_results++;
			end
			m_tready <= !receiver_stalls();
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
			else idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("timeout: no transfer for %0d cycles", STALL_LIMIT);
				$display("FAIL access_category_frame_queues_top");
				$finish;
			end
		end
	end

	initial begin
		int          roll;
		int          n_broken;
		int          n_directed;
		logic [1:0]  q;
		logic [6:0]  rate;
		logic [3:0]  pwr;

		// directed: unknown op, clear, empty read, ignored index, extreme frame and its readback
		plan_op('{op: OP_BAD, ac: 2'd3, idx: 4'hf, word: '1, rate: '1, pwr: '1});
		plan_op('{op: OP_CLEAR, ac: 2'd0, idx: 4'h0, word: '0, rate: '0, pwr: '0});
		plan_op('{op: OP_DEQ, ac: 2'd0, idx: 4'h0, word: '0, rate: '0, pwr: '0});
		plan_op('{op: OP_ENQ, ac: 2'd2, idx: 4'hf, word: '1, rate: '1, pwr: '1});
		plan_op('{op: OP_ENQ, ac: 2'd2, idx: 4'(WORDS), word: '1, rate: '0, pwr: '0});
		for (int k = 0; k < WORDS; k++) begin
			plan_op('{op: OP_ENQ, ac: 2'd3, idx: 4'(k), word: (k % 2 == 0) ? '1 : '0,
				rate: '1, pwr: '1});
		end
		plan_op('{op: OP_DEQ, ac: 2'd3, idx: 4'h0, word: '0, rate: '0, pwr: '0});
		plan_op('{op: OP_DEQ, ac: 2'd3, idx: 4'hf, word: '1, rate: '1, pwr: '1});
		n_directed = pending_ops.size();

		// random: mostly whole frames to a busy queue, then reads, broken word runs and noise
		while (pending_ops.size() < n_directed + RAND_ITEMS) begin
			roll = $urandom_range(0, 99);
			q    = ($urandom_range(0, 9) < 5) ? 2'd1 : 2'($urandom_range(0, 3));
			if (roll < 40) begin
				rate = 7'($urandom_range(0, 127));
				pwr  = 4'($urandom_range(0, 15));
				for (int k = 0; k < WORDS; k++) begin
					plan_op('{op: OP_ENQ, ac: q, idx: 4'(k), word: {$urandom, $urandom},
						rate: (k == LAST_IDX) ? rate : 7'($urandom_range(0, 127)),
						pwr: (k == LAST_IDX) ? pwr : 4'($urandom_range(0, 15))});
				end
			end else if (roll < 64) begin
				plan_op('{op: OP_DEQ, ac: 2'($urandom_range(0, 3)), idx: 4'($urandom_range(0, 15)),
					word: {$urandom, $urandom}, rate: 7'($urandom_range(0, 127)),
					pwr: 4'($urandom_range(0, 15))});
			end else if (roll < 86) begin
				n_broken = $urandom_range(1, 6);
				for (int k = 0; k < n_broken; k++) begin
					plan_op('{op: OP_ENQ, ac: 2'($urandom_range(0, 3)),
						idx: 4'($urandom_range(0, 15)), word: {$urandom, $urandom},
						rate: 7'($urandom_range(0, 127)), pwr: 4'($urandom_range(0, 15))});
				end
			end else if (roll < 94) begin
				plan_op('{op: OP_BAD, ac: 2'($urandom_range(0, 3)), idx: 4'($urandom_range(0, 15)),
					word: {$urandom, $urandom}, rate: 7'($urandom_range(0, 127)),
					pwr: 4'($urandom_range(0, 15))});
			end else begin
				plan_op('{op: OP_CLEAR, ac: 2'($urandom_range(0, 3)),
					idx: 4'($urandom_range(0, 15)), word: {$urandom, $urandom},
					rate: 7'($urandom_range(0, 127)), pwr: 4'($urandom_range(0, 15))});
			end
		end
		n_planned = pending_ops.size();

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		while (n_accepted != n_planned) @(posedge clk);
		while (frame_results.size() != 0) @(posedge clk);
		repeat (WORDS + 8) @(posedge clk);

		$display("run covered %0d operations and %0d result transfers: %0d frames read back,",
			n_accepted, n_results, n_frames_out);
		$display("%0d full refusals, %0d empty reads, %0d clears, %0d unknown operations",
			n_full, n_empty, n_clears, n_badops);
		if (n_errors == 0 && frame_results.size() == 0) begin
			$display("PASS access_category_frame_queues_top");
		end else begin
			$display("FAIL access_category_frame_queues_top");
		end
		$finish;
	end

endmodule

### access_category_frame_queues_top.f
sv/acfq_pkg.sv
sv/acfq_ram.sv
sv/access_category_frame_queues_top.sv
bench/tb_top.sv
